@@ rtl/txr_pkg.sv @@
// Package for the transmit ring: request and result types, action and status codes.
// No dependencies; the ring, the checker and the testbench import it.
package txr_pkg;

    // Request action codes
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_DONE  = 2'd1;
    localparam logic [1:0] ACT_FETCH = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  data_byte;
        logic [15:0] message_length;
        logic        first_of_message;
        logic        last_of_message;
        logic [7:0]  fetch_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        transfer_arm;
        logic [7:0]  transfer_offset;
        logic [7:0]  transfer_length;
        logic [7:0]  fetched_byte;
        logic        busy_res;
        logic [7:0]  bytes_used;
        logic [31:0] full_events;
    } t_rsp;

endpackage

@@ rtl/txr_stream_if.sv @@
// Valid/ready channel carrying one payload of type T per request.
// Used with txr_pkg::t_req and txr_pkg::t_rsp payloads.
interface txr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tx_ring_with_dma_chunking.sv @@
// Transmit ring with DMA run arming. Message bytes, transfer completions and
// fetches arrive on i_req; each accepted request yields exactly one result on
// o_rsp through the result register. One request is taken every cycle unless a
// held result stalls the input; a new request is taken even while the previous
// result is still waiting, as long as that result leaves this cycle. Throughput
// is set by the single result register and the one-read-one-write ring memory,
// read in the same cycle as the fetch is accepted. One ring slot always stays
// free, so at most RING_SIZE-1 bytes are committed. The ring memory is not
// cleared at reset; fetching a slot never written returns an undefined byte.
module tx_ring_with_dma_chunking #(
    parameter int RING_SIZE = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    txr_stream_if.sink           i_req,
    txr_stream_if.source         o_rsp
);
    import txr_pkg::*;

    localparam int PW = $clog2(RING_SIZE);

    localparam logic [PW-1:0] LAST_SLOT = PW'(RING_SIZE - 1);
    localparam logic [PW:0]   RS_W      = (PW + 1)'(RING_SIZE);

    typedef logic [PW-1:0] t_mod_tab [256];

    // Map an 8-bit fetch offset onto a ring slot
    function automatic t_mod_tab build_mod_tab();
        t_mod_tab tab;
        int       c;
        c = 0;
        for (int i = 0; i < 256; i++) begin
            tab[i] = PW'(c);
            c = (c == RING_SIZE - 1) ? 0 : c + 1;
        end
        return tab;
    endfunction

    localparam t_mod_tab MOD_TAB = build_mod_tab();

    // Committed bytes between drain and commit pointers
    function automatic logic [PW-1:0] used_of(logic [PW-1:0] c, logic [PW-1:0] d);
        logic [PW:0] diff;
        diff = {1'b0, c} - {1'b0, d};
        if (c < d) begin
            diff = diff + RS_W;
        end
        return diff[PW-1:0];
    endfunction

    // Ring memory
    logic [7:0] r_mem [RING_SIZE];

    // Control state
    logic [PW-1:0] r_commit, n_commit;
    logic [PW-1:0] r_wptr,   n_wptr;
    logic [PW-1:0] r_drain,  n_drain;
    logic [PW-1:0] r_run,    n_run;
    logic          r_busy,   n_busy;
    logic          r_drop,   n_drop;
    logic [31:0]   r_cnt,    n_cnt;

    // Result stage
    logic          r_out_valid;
    t_rsp          r_rsp, n_rsp;
    logic          r_is_fetch;
    logic [7:0]    r_rd_byte;

    logic          accept;
    logic          mem_we;
    logic [PW-1:0] wp_base;
    logic [PW-1:0] wp_next;
    logic [PW-1:0] used_now;
    logic [16:0]   free_now;
    logic [PW:0]   drain_sum;
    logic [PW-1:0] drain_adv;
    logic [PW-1:0] used_x;
    logic [PW:0]   to_end;
    logic [PW-1:0] run_len;
    logic          arm;
    t_req          req;

    assign req    = i_req.data;
    assign accept = i_req.valid && i_req.ready;

    // Take a request whenever the result register is empty or drains now
    assign i_req.ready = !r_out_valid || o_rsp.ready;

    assign used_now  = used_of(r_commit, r_drain);
    assign free_now  = 17'(RING_SIZE - 1) - 17'(used_now);
    assign wp_base   = req.first_of_message ? r_commit : r_wptr;
    assign wp_next   = (wp_base == LAST_SLOT) ? '0 : wp_base + 1'b1;
    assign drain_sum = {1'b0, r_drain} + {1'b0, r_run};
    assign drain_adv = (drain_sum >= RS_W) ? PW'(drain_sum - RS_W) : drain_sum[PW-1:0];

    // Run from the new drain pointer to the wrap point or the commit pointer
    assign used_x  = used_of(n_commit, n_drain);
    assign to_end  = RS_W - {1'b0, n_drain};
    assign run_len = ({1'b0, used_x} < to_end) ? used_x : to_end[PW-1:0];

    // Next state and result for the request at the input
    always_comb begin
        logic take;
        n_commit = r_commit;
        n_wptr   = r_wptr;
        n_drain  = r_drain;
        n_run    = r_run;
        n_busy   = r_busy;
        n_drop   = r_drop;
        n_cnt    = r_cnt;
        mem_we   = 1'b0;
        arm      = 1'b0;
        take     = 1'b0;
        n_rsp    = '0;
        n_rsp.status = ST_OK;

        case (req.action)
            ACT_BYTE: begin
                take   = 1'b1;
                n_wptr = wp_base;
                if (req.first_of_message) begin
                    n_drop = 1'b0;
                    if (req.message_length == '0) begin
                        n_rsp.status = ST_ZERO;
                        take         = 1'b0;
                        n_drop       = !req.last_of_message;
                    end else if (free_now < {1'b0, req.message_length}) begin
                        n_rsp.status = ST_FULL;
                        n_cnt        = r_cnt + 32'd1;
                        take         = 1'b0;
                        n_drop       = !req.last_of_message;
                    end
                end else if (r_drop) begin
                    n_rsp.status = ST_FULL;
                    take         = 1'b0;
                    if (req.last_of_message) begin
                        n_drop = 1'b0;
                    end
                end
                if (take) begin
                    if (wp_next == r_drain) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        mem_we = 1'b1;
                        n_wptr = wp_next;
                    end
                    if (req.last_of_message) begin
                        n_commit = n_wptr;
                        if (!r_busy && used_of(n_wptr, r_drain) != '0) begin
                            n_busy = 1'b1;
                            arm    = 1'b1;
                        end
                    end
                end
            end
            ACT_DONE: begin
                if (r_busy) begin
                    n_drain = drain_adv;
                    n_run   = '0;
                    if (used_of(r_commit, drain_adv) != '0) begin
                        arm = 1'b1;
                    end else begin
                        n_busy = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        if (arm) begin
            n_run                 = run_len;
            n_rsp.transfer_arm    = 1'b1;
            n_rsp.transfer_offset = 8'(n_drain);
            n_rsp.transfer_length = 8'(run_len);
        end
        n_rsp.busy_res    = n_busy;
        n_rsp.bytes_used  = 8'(used_x);
        n_rsp.full_events = n_cnt;
    end

    // Hold ring state; advance on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_commit <= '0;
            r_wptr   <= '0;
            r_drain  <= '0;
            r_run    <= '0;
            r_busy   <= 1'b0;
            r_drop   <= 1'b0;
            r_cnt    <= '0;
        end else if (accept) begin
            r_commit <= n_commit;
            r_wptr   <= n_wptr;
            r_drain  <= n_drain;
            r_run    <= n_run;
            r_busy   <= n_busy;
            r_drop   <= n_drop;
            r_cnt    <= n_cnt;
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            r_mem[wp_base] <= req.data_byte;
        end
        if (accept && req.action == ACT_FETCH) begin
            r_rd_byte <= r_mem[MOD_TAB[req.fetch_offset]];
        end
    end

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp      <= n_rsp;
            r_is_fetch <= (req.action == ACT_FETCH);
        end
    end

    // Drive the result channel; fetched byte comes straight from the read register
    always_comb begin
        o_rsp.valid = r_out_valid;
        o_rsp.data  = r_rsp;
        o_rsp.data.fetched_byte = r_is_fetch ? r_rd_byte : 8'd0;
    end

endmodule

@@ rtl/txr_checker.sv @@
// Port-level checks for the transmit ring, bound onto the top level.
// Depends on txr_pkg for the request and result types.
module txr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input txr_pkg::t_rsp  i_rsp_data
);
    import txr_pkg::*;

    // No result is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // Every accepted request shows a result in the next cycle
    a_req_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> i_rsp_valid)
        else $error("accepted request produced no result");

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled result dropped or changed");

    // An armed run is non-empty and leaves a transfer outstanding
    a_arm_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_data.transfer_arm) |->
            (i_rsp_data.busy_res && i_rsp_data.transfer_length != 8'd0))
        else $error("armed run empty or block not busy");

    // Without an arm the run fields read zero
    a_no_arm_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_data.transfer_arm) |->
            (i_rsp_data.transfer_offset == 8'd0 && i_rsp_data.transfer_length == 8'd0))
        else $error("run fields set without arm");

endmodule

bind tx_ring_with_dma_chunking txr_checker u_txr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

@@ test/tx_ring_with_dma_chunking_tb.sv @@
// Testbench for the transmit ring with DMA run arming: directed, ring-fill, stall and random
// traffic, each result checked against an in-bench model of the ring pointers and store.
// Depends on txr_pkg and txr_stream_if from the RTL, and on tx_ring_with_dma_chunking.
`timescale 1ns / 100ps

module tx_ring_with_dma_chunking_tb;
    import txr_pkg::*;

    localparam int         RING_DEPTH  = 256;
    localparam int         HOLD_CYCLES = 200;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    logic i_clk;
    logic i_rst_n;

    txr_stream_if #(.T(t_req)) req_if ();
    txr_stream_if #(.T(t_rsp)) rsp_if ();

    tx_ring_with_dma_chunking #(.RING_SIZE(RING_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Ring model state, starting from the post-reset values
    bit [7:0]  ring_mem     [RING_DEPTH];
    bit        slot_written [RING_DEPTH];
    int        commit_ptr = 0;
    int        wr_ptr     = 0;
    int        drain_ptr  = 0;
    int        run_len    = 0;
    bit        xfer_busy  = 1'b0;
    bit        dropping   = 1'b0;
    bit [31:0] full_cnt   = '0;

    t_rsp outcome_q [$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_req     = 1'b0;
    bit hold_ack     = 1'b0;
    int hold_left    = 0;

    int n_sent      = 0;
    int n_checked   = 0;
    int n_mismatch  = 0;
    int n_armed     = 0;
    int n_fetch     = 0;
    int n_discarded = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard limit on run time
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int used_now();
        return (commit_ptr + RING_DEPTH - drain_ptr) % RING_DEPTH;
    endfunction

    // Arm the contiguous run from the drain pointer up to the wrap point or the commit pointer
    function automatic void arm_run(inout t_rsp o);
        int to_end;
        to_end = RING_DEPTH - drain_ptr;
        run_len = (used_now() < to_end) ? used_now() : to_end;
        o.transfer_arm    = 1'b1;
        o.transfer_offset = drain_ptr[7:0];
        o.transfer_length = run_len[7:0];
        n_armed++;
    endfunction

    // Advance the ring model by one request and return the result it must produce
    function automatic t_rsp ring_outcome(t_req r);
        t_rsp o;
        bit   take;
        int   nxt;
        o = '0;
        o.status = ST_OK;
        case (r.action)
            ACT_BYTE: begin
                take = 1'b1;
                if (r.first_of_message) begin
                    wr_ptr   = commit_ptr;
                    dropping = 1'b0;
                    if (r.message_length == 16'd0) begin
                        o.status = ST_ZERO;
                        take     = 1'b0;
                        dropping = !r.last_of_message;
                    end else if (RING_DEPTH - 1 - used_now() < int'(r.message_length)) begin
                        o.status = ST_FULL;
                        full_cnt++;
                        take     = 1'b0;
                        dropping = !r.last_of_message;
                    end
                end else if (dropping) begin
                    o.status = ST_FULL;
                    take     = 1'b0;
                    if (r.last_of_message) dropping = 1'b0;
                end
                if (take) begin
                    nxt = (wr_ptr + 1) % RING_DEPTH;
                    if (nxt == drain_ptr) begin
                        o.status = ST_FULL;
                        n_discarded++;
                    end else begin
                        ring_mem[wr_ptr]     = r.data_byte;
                        slot_written[wr_ptr] = 1'b1;
                        wr_ptr               = nxt;
                    end
                    if (r.last_of_message) begin
                        commit_ptr = wr_ptr;
                        if (!xfer_busy && used_now() > 0) begin
                            xfer_busy = 1'b1;
                            arm_run(o);
                        end
                    end
                end
            end
            ACT_DONE: begin
                if (xfer_busy) begin
                    drain_ptr = (drain_ptr + run_len) % RING_DEPTH;
                    run_len   = 0;
                    if (used_now() > 0) arm_run(o);
                    else xfer_busy = 1'b0;
                end
            end
            ACT_FETCH: begin
                o.fetched_byte = ring_mem[int'(r.fetch_offset) % RING_DEPTH];
                n_fetch++;
            end
            default: ;
        endcase
        o.busy_res    = xfer_busy;
        o.bytes_used  = 8'(used_now());
        o.full_events = full_cnt;
        return o;
    endfunction

    function automatic t_req byte_req(bit [7:0] d, bit [15:0] len, bit first, bit last);
        t_req r;
        r.action           = ACT_BYTE;
        r.data_byte        = d;
        r.message_length   = len;
        r.first_of_message = first;
        r.last_of_message  = last;
        r.fetch_offset     = 8'($urandom);
        return r;
    endfunction

    function automatic t_req ctrl_req(logic [1:0] act, bit [7:0] off);
        t_req r;
        r.first_of_message = 1'($urandom);
        r.last_of_message  = 1'($urandom);
        r.action           = act;
        r.data_byte        = 8'($urandom);
        r.message_length   = 16'($urandom);
        r.fetch_offset     = off;
        return r;
    endfunction

    // Offer one request, hold it until taken, and queue its expected result
    task automatic send_req(input t_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(negedge i_clk);
        while (req_if.ready !== 1'b1) @(negedge i_clk);
        outcome_q.push_back(ring_outcome(r));
        if (r.action != ACT_UNUSED) n_sent++;
        @(posedge i_clk);
    endtask

    // Send nbytes message bytes; the length rides on the first, last marks the final one when close is set
    task automatic send_message(input bit [15:0] len, input int nbytes, input bit close);
        for (int k = 0; k < nbytes; k++) begin
            send_req(byte_req(8'($urandom), (k == 0) ? len : 16'($urandom), k == 0,
                              close && (k == nbytes - 1)));
        end
    endtask

    // Drop valid and wait until every queued result has been checked
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outcome_q.size() != 0) @(posedge i_clk);
    endtask

    // Pick one slot that has been written at least once
    function automatic bit [7:0] written_slot();
        int s;
        do s = $urandom_range(RING_DEPTH - 1); while (!slot_written[s]);
        return s[7:0];
    endfunction

    // Mostly well-formed messages with completions and fetches, plus some noise
    task automatic random_item(output int cnt);
        int        pick;
        int        shape;
        int        nbytes;
        bit        close;
        bit [15:0] len;
        pick = $urandom_range(99);
        cnt  = 1;
        if (pick < 55) begin
            shape = $urandom_range(99);
            if (shape < 80)      len = 16'($urandom_range(1, 12));
            else if (shape < 92) len = 16'($urandom_range(13, 120));
            else if (shape < 97) len = 16'($urandom);
            else                 len = 16'd0;
            nbytes = (len == 16'd0 || len > 16'd255) ? $urandom_range(1, 3) : int'(len);
            shape  = $urandom_range(99);
            close  = 1'b1;
            if (shape < 8) begin
                nbytes += $urandom_range(1, 3);
            end else if (shape < 15) begin
                close  = 1'b0;
                nbytes = $urandom_range(1, nbytes);
            end
            send_message(len, nbytes, close);
            cnt = nbytes;
        end else if (pick < 75) begin
            send_req(ctrl_req(ACT_DONE, 8'($urandom)));
        end else if (pick < 90) begin
            send_req(ctrl_req(ACT_FETCH, written_slot()));
        end else if (pick < 95) begin
            send_req(byte_req(8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom)));
        end else begin
            send_req(ctrl_req(ACT_UNUSED, 8'($urandom)));
            cnt = 0;
        end
    endtask

    // Short directed walk through the special cases
    task automatic test_directed();
        send_req(ctrl_req(ACT_DONE, 8'd0));
        send_req(ctrl_req(ACT_UNUSED, 8'hff));
        send_req(byte_req(8'h11, 16'd0, 1'b1, 1'b1));
        send_req(byte_req(8'h22, 16'd0, 1'b1, 1'b0));
        send_req(byte_req(8'h33, 16'd7, 1'b0, 1'b0));
        send_req(byte_req(8'h44, 16'd7, 1'b0, 1'b1));
        send_req(byte_req(8'h00, 16'd3, 1'b1, 1'b0));
        send_req(byte_req(8'hff, 16'd0, 1'b0, 1'b0));
        send_req(byte_req(8'h5a, 16'd0, 1'b0, 1'b1));
        send_req(ctrl_req(ACT_FETCH, 8'd0));
        send_req(ctrl_req(ACT_FETCH, 8'd2));
        // commit while a run is in flight, then complete twice
        send_message(16'd2, 2, 1'b1);
        send_req(ctrl_req(ACT_DONE, 8'd0));
        send_req(ctrl_req(ACT_DONE, 8'd0));
        // rejected on length, including the widest length, and a restart mid-drop
        send_req(byte_req(8'h01, 16'hffff, 1'b1, 1'b0));
        send_req(byte_req(8'h02, 16'd256, 1'b1, 1'b1));
        // largest admissible length, then restarted by a one-byte message
        send_req(byte_req(8'h03, 16'd255, 1'b1, 1'b0));
        send_req(byte_req(8'h04, 16'd1, 1'b1, 1'b1));
        // bytes with no first marker extend at the commit pointer
        send_req(byte_req(8'h05, 16'd0, 1'b0, 1'b0));
        send_req(byte_req(8'h06, 16'd0, 1'b0, 1'b1));
        send_req(ctrl_req(ACT_DONE, 8'd0));
        send_req(ctrl_req(ACT_DONE, 8'd0));
    endtask

    // Overrun the ring with one long message, hit the full check, drain across the wrap
    task automatic test_ring_fill();
        send_message(16'd4, RING_DEPTH + 1, 1'b1);
        send_message(16'd1, 1, 1'b1);
        send_req(ctrl_req(ACT_DONE, 8'd0));
        send_req(ctrl_req(ACT_DONE, 8'd0));
        send_req(ctrl_req(ACT_DONE, 8'd0));
        repeat (6) send_req(ctrl_req(ACT_FETCH, written_slot()));
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int cnt;
        sent = 0;
        while (sent < n_items) begin
            random_item(cnt);
            sent += cnt;
        end
    endtask

    // Hold the receiver off long enough that the block stalls its input
    task automatic test_stalled_receiver();
        int sent;
        int cnt;
        sent = 0;
        hold_req <= ~hold_req;
        while (sent < 40) begin
            random_item(cnt);
            sent += cnt;
        end
        wait_drained();
    endtask

    // Drive result ready: long hold-off on request, random idling otherwise
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            rsp_if.ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            rsp_if.ready  <= 1'b0;
        end else begin
            rsp_if.ready  <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         n_checked, fname, want, got);
        end
    endtask

    // Compare each result taken at the coming edge with the oldest expectation
    always @(negedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got = rsp_if.data;
            if (outcome_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("result with no request pending: 0x%0h", got);
            end else begin
                want = outcome_q.pop_front();
                n_checked++;
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("transfer_arm", 32'(want.transfer_arm), 32'(got.transfer_arm));
                check_field("transfer_offset", 32'(want.transfer_offset),
                            32'(got.transfer_offset));
                check_field("transfer_length", 32'(want.transfer_length),
                            32'(got.transfer_length));
                check_field("fetched_byte", 32'(want.fetched_byte), 32'(got.fetched_byte));
                check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
                check_field("bytes_used", 32'(want.bytes_used), 32'(got.bytes_used));
                check_field("full_events", want.full_events, got.full_events);
            end
        end
    end

    // Sequence the tests
    initial begin
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 27;
        snk_idle_pct <= 61;
        test_directed();
        wait_drained();
        test_ring_fill();
        wait_drained();
        test_random_traffic(125);

        src_idle_pct = 61;
        snk_idle_pct <= 27;
        test_random_traffic(125);
        test_stalled_receiver();

        src_idle_pct = 0;
        snk_idle_pct <= 0;
        test_random_traffic(125);

        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d results, %0d field mismatches.",
                 n_sent, n_checked, n_mismatch);
        $display("Runs armed %0d, rejected messages %0d, overrun bytes %0d, fetches %0d.",
                 n_armed, full_cnt, n_discarded, n_fetch);
        if (n_mismatch == 0 && outcome_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
